// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b at the same clock edge
`define ASSERT_IMPLIES(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("implication check failed");

// property p never holds at a clock edge
`define ASSERT_NEVER(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) !(p)) \
    else $error("forbidden condition seen");

`endif

// ----- rtl/core/asvg_pkg.sv -----
// Package for the arc strip vertex generator: constants, register codes, types
`timescale 1ns / 1ps
package asvg_pkg;

  localparam int MAX_SEGMENTS_DEF  = 256;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int REG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 16;

  localparam logic [14:0] FULL_CIRCLE = 15'd23040;
  localparam logic [31:0] FULL_WRAP   = 32'd1509949440;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  // ceil(2^43 / 45): phase = (angle * PHASE_RECIP) >> 36, exact below 2^31
  localparam logic [37:0] PHASE_RECIP = 38'd195468733827;

  localparam logic [31:0] ATAN_TURNS [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_RADIUS_X    = 3'd2,
    REG_RADIUS_Y    = 3'd3,
    REG_START_ANGLE = 3'd4,
    REG_END_ANGLE   = 3'd5,
    REG_THICKNESS   = 3'd6,
    REG_SEGMENTS    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [16:0] slot;
    logic        outer;
    logic        last;
    logic        err;
  } tag_t;

endpackage

// ----- rtl/core/arc_strip_vertex_generator.sv -----
// Arc strip vertex generator top level: fully pipelined vertex datapath
`timescale 1ns / 1ps
// Usage
//   Configuration: cfg_write/cfg_index/cfg_data writes one register per cycle.
//   The user must write only while no item is in flight (unchecked). No read-back.
//   Request channel: an item (vertex_index, base_slot) is taken at each clock
//   edge with start high and busy low. busy stays low, so one item per cycle.
//   Result channel: done marks one cycle carrying vertex_x, vertex_y, slot,
//   outer_ring, last_vertex and index_error; it cannot be held off.
//   Pipeline from accept to done: one decode stage, one multiply, a 20-stage
//   divider by the segment count (2 quotient bits per stage), one angle add and
//   wrap, a two-stage reciprocal multiply for the phase, one fold stage, one
//   CORDIC iteration per stage, one scale multiply and one round and saturate
//   stage.
//   Throughput: one item per cycle, set by the fully pipelined datapath.
//   Reset: rst clears the registers to their reset values and drops every
//   item in flight; nothing is returned for them.
module arc_strip_vertex_generator #(
  parameter int MAX_SEGMENTS  = asvg_pkg::MAX_SEGMENTS_DEF,
  parameter int CORDIC_STAGES = asvg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [asvg_pkg::REG_INDEX_W-1:0]  cfg_index,
  input  logic [asvg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [9:0]                        vertex_index,
  input  logic [15:0]                       base_slot,
  output logic                              done,
  output logic signed [15:0]                vertex_x,
  output logic signed [15:0]                vertex_y,
  output logic [16:0]                       slot,
  output logic                              outer_ring,
  output logic                              last_vertex,
  output logic                              index_error
);
  import asvg_pkg::*;

  localparam int DIV_W      = 40;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = DIV_W / DIV_BITS;
  localparam int LATENCY    = DIV_STAGES + CORDIC_STAGES + 8;

  logic signed [15:0] center_x, center_y, radius_x, radius_y, thickness;
  logic [14:0] start_angle, end_angle;
  logic [8:0]  segment_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      radius_x      <= 16'sd4096;
      radius_y      <= 16'sd4096;
      start_angle   <= '0;
      end_angle     <= '0;
      thickness     <= '0;
      segment_count <= 9'd1;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_CENTER_X:    center_x      <= signed'(cfg_data);
        REG_CENTER_Y:    center_y      <= signed'(cfg_data);
        REG_RADIUS_X:    radius_x      <= signed'(cfg_data);
        REG_RADIUS_Y:    radius_y      <= signed'(cfg_data);
        REG_START_ANGLE: start_angle   <= cfg_data[14:0];
        REG_END_ANGLE:   end_angle     <= cfg_data[14:0];
        REG_THICKNESS:   thickness     <= signed'(cfg_data);
        REG_SEGMENTS:    segment_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DIV_W+8:0] ndiv_step(input logic [DIV_W-1:0] w_in,
                                                 input logic [8:0] r_in,
                                                 input logic [8:0] d);
    logic [DIV_W-1:0] w;
    logic [9:0] t;
    logic [8:0] r;
    w = w_in;
    r = r_in;
    for (int b = 0; b < DIV_BITS; b++) begin
      t = {r, w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        w[0] = 1'b1;
      end
      r = t[8:0];
    end
    return {r, w};
  endfunction

  // shared decode of the configuration
  logic [14:0] start_w, end_w, span_c;
  logic [8:0]  n_c;
  logic [10:0] last_idx;

  always_comb begin
    start_w = (start_angle >= FULL_CIRCLE) ? start_angle - FULL_CIRCLE : start_angle;
    end_w   = (end_angle >= FULL_CIRCLE) ? end_angle - FULL_CIRCLE : end_angle;
    if (start_w <= end_w) span_c = end_w - start_w;
    else span_c = FULL_CIRCLE - start_w + end_w;
    if (segment_count == 9'd0) n_c = 9'd1;
    else if (32'(segment_count) > MAX_SEGMENTS) n_c = 9'(MAX_SEGMENTS);
    else n_c = segment_count;
    last_idx = {1'b0, n_c, 1'b0} + 11'd3;
  end

  // index decode of the incoming item
  logic [8:0]  p_c;
  logic [9:0]  vidx_m1;
  tag_t        tag_c;

  always_comb begin
    vidx_m1     = vertex_index - 10'd1;
    tag_c.slot  = {1'b0, base_slot} + {7'b0, vertex_index};
    tag_c.err   = {1'b0, vertex_index} > last_idx;
    tag_c.last  = {1'b0, vertex_index} == last_idx;
    if (vertex_index == 10'd0) begin
      p_c         = '0;
      tag_c.outer = 1'b0;
    end else if (tag_c.last) begin
      p_c         = n_c;
      tag_c.outer = 1'b1;
    end else begin
      p_c         = vidx_m1[9:1];
      tag_c.outer = vidx_m1[0];
    end
  end

  tag_t tag_line [0:LATENCY-1];
  logic vld_line [0:LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LATENCY; k++) vld_line[k] <= 1'b0;
    end else begin
      vld_line[0] <= start & ~busy;
      for (int k = 1; k < LATENCY; k++) vld_line[k] <= vld_line[k-1];
    end
  end

  always_ff @(posedge clk) begin
    tag_line[0] <= tag_c;
    for (int k = 1; k < LATENCY; k++) tag_line[k] <= tag_line[k-1];
  end

  // angle offset: floor(p*span*2^16 / n)
  logic [8:0]       a_p;
  logic [23:0]      prod_c;
  logic [DIV_W-1:0] div_w [0:DIV_STAGES];
  logic [8:0]       div_r [0:DIV_STAGES];

  assign prod_c = {15'b0, a_p} * {9'b0, span_c};

  always_ff @(posedge clk) begin
    a_p      <= p_c;
    div_w[0] <= {prod_c, 16'h0000};
    div_r[0] <= '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      {div_r[s+1], div_w[s+1]} <= ndiv_step(div_w[s], div_r[s], n_c);
    end
  end

  // absolute angle, then phase = floor(angle*128/45) by reciprocal multiply
  logic [31:0] total_c, total_w;
  logic [30:0] total_r;
  logic [49:0] ph_hi, ph_lo;
  logic [69:0] ph_sum;
  logic [31:0] phase_r;

  always_comb begin
    total_c = {1'b0, start_w, 16'h0000} + {1'b0, div_w[DIV_STAGES][30:0]};
    total_w = (total_c >= FULL_WRAP) ? total_c - FULL_WRAP : total_c;
  end

  assign ph_sum = {1'b0, ph_hi, 19'b0} + {20'b0, ph_lo};

  always_ff @(posedge clk) begin
    total_r <= total_w[30:0];
    ph_hi   <= {19'b0, total_r} * {31'b0, PHASE_RECIP[37:19]};
    ph_lo   <= {19'b0, total_r} * {31'b0, PHASE_RECIP[18:0]};
    phase_r <= ph_sum[67:36];
  end

  // fold into +-90 degrees and rotate
  logic signed [33:0] z_c;
  logic               neg_c;
  logic signed [33:0] cx [0:CORDIC_STAGES];
  logic signed [33:0] cy [0:CORDIC_STAGES];
  logic signed [33:0] cz [0:CORDIC_STAGES];
  logic               cneg [0:CORDIC_STAGES];

  always_comb begin
    z_c   = 34'(signed'(phase_r));
    neg_c = 1'b0;
    if (z_c > 34'sd1073741824) begin
      z_c   = z_c - 34'sd2147483648;
      neg_c = 1'b1;
    end else if (z_c < -34'sd1073741824) begin
      z_c   = z_c + 34'sd2147483648;
      neg_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cx[0]   <= CORDIC_GAIN;
    cy[0]   <= '0;
    cz[0]   <= z_c;
    cneg[0] <= neg_c;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      cneg[i+1] <= cneg[i];
      if (cz[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - signed'({2'b00, ATAN_TURNS[i]});
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + signed'({2'b00, ATAN_TURNS[i]});
      end
    end
  end

  // scale by the radii
  logic signed [33:0] cos_c, sin_c;
  logic signed [31:0] cos_t, sin_t;
  logic signed [16:0] scale_x, scale_y;
  logic signed [48:0] mx, my;

  always_comb begin
    cos_c = cneg[CORDIC_STAGES] ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
    sin_c = cneg[CORDIC_STAGES] ? -cy[CORDIC_STAGES] : cy[CORDIC_STAGES];
    cos_t = signed'(cos_c[31:0]);
    sin_t = signed'(sin_c[31:0]);
    scale_x = 17'(radius_x);
    scale_y = 17'(radius_y);
    if (tag_line[LATENCY-3].outer) begin
      scale_x = scale_x + 17'(thickness);
      scale_y = scale_y + 17'(thickness);
    end
  end

  always_ff @(posedge clk) begin
    mx <= 49'(cos_t) * 49'(scale_x);
    my <= 49'(sin_t) * 49'(scale_y);
  end

  // round, offset by the centre, saturate
  logic signed [49:0] rx, ry;
  logic signed [20:0] sx, sy;
  logic signed [15:0] sat_x, sat_y;

  always_comb begin
    rx = 50'(mx) + 50'sd536870912;
    ry = 50'(my) + 50'sd536870912;
    sx = 21'(center_x) + 21'(signed'(rx[49:30]));
    sy = 21'(center_y) + 21'(signed'(ry[49:30]));
    if (sx > 21'sd32767) sat_x = 16'sd32767;
    else if (sx < -21'sd32768) sat_x = -16'sd32768;
    else sat_x = sx[15:0];
    if (sy > 21'sd32767) sat_y = 16'sd32767;
    else if (sy < -21'sd32768) sat_y = -16'sd32768;
    else sat_y = sy[15:0];
  end

  always_ff @(posedge clk) begin
    vertex_x <= tag_line[LATENCY-2].err ? '0 : sat_x;
    vertex_y <= tag_line[LATENCY-2].err ? '0 : sat_y;
  end

  assign busy        = 1'b0;
  assign done        = vld_line[LATENCY-1];
  assign slot        = tag_line[LATENCY-1].slot;
  assign index_error = tag_line[LATENCY-1].err;
  assign outer_ring  = tag_line[LATENCY-1].outer & ~tag_line[LATENCY-1].err;
  assign last_vertex = tag_line[LATENCY-1].last & ~tag_line[LATENCY-1].err;

endmodule

// ----- rtl/core/asvg_checker.sv -----
// Port-level checker for the arc strip vertex generator, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module asvg_checker #(
  parameter int LATENCY = 44
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_write,
  input logic [asvg_pkg::REG_INDEX_W-1:0]  cfg_index,
  input logic [asvg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input logic                              start,
  input logic                              busy,
  input logic [9:0]                        vertex_index,
  input logic [15:0]                       base_slot,
  input logic                              done,
  input logic signed [15:0]                vertex_x,
  input logic signed [15:0]                vertex_y,
  input logic [16:0]                       slot,
  input logic                              outer_ring,
  input logic                              last_vertex,
  input logic                              index_error
);
  import asvg_pkg::*;

  logic err_clean, item_in;
  logic [16:0] slot_in;

  assign err_clean  = (vertex_x == 16'sd0) && (vertex_y == 16'sd0) && !outer_ring
                      && !last_vertex;
  assign item_in    = start && !busy;
  assign slot_in    = {1'b0, base_slot} + {7'b0, vertex_index};

  `ASSERT_IMPLIES(err_item_zeroed, clk, rst, done && index_error, err_clean)
  `ASSERT_IMPLIES(last_is_outer, clk, rst, done && last_vertex, outer_ring)
  `ASSERT_IMPLIES(done_follows_item, clk, rst, done, $past(item_in, LATENCY))
  `ASSERT_IMPLIES(slot_follows_item, clk, rst, done, slot == $past(slot_in, LATENCY))
  `ASSERT_NEVER(never_busy, clk, rst, busy)

endmodule

bind arc_strip_vertex_generator asvg_checker #(.LATENCY(LATENCY)) u_asvg_checker (.*);

// ----- sim/tb_arc_strip_vertex_generator.sv -----
// Testbench for the arc strip vertex generator: directed and random vertex requests
`timescale 1ns / 1ps
module tb_arc_strip_vertex_generator;
  import asvg_pkg::*;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [16:0]        sl;
    logic               outer;
    logic               last;
    logic               err;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [9:0] vertex_index = '0;
  logic [15:0] base_slot = '0;
  logic done;
  logic signed [15:0] vertex_x, vertex_y;
  logic [16:0] slot;
  logic outer_ring, last_vertex, index_error;

  logic [15:0] cx_r, cy_r, rx_r, ry_r, th_r;
  logic [14:0] sa_r, ea_r;
  logic [8:0]  seg_r;
  vertex_t expected_q[$];
  int errors = 0;
  int idle_pct = 0;

  arc_strip_vertex_generator i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .start, .busy,
    .vertex_index, .base_slot, .done, .vertex_x, .vertex_y, .slot,
    .outer_ring, .last_vertex, .index_error
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic vertex_t predict_vertex(logic [9:0] vi, logic [15:0] bs);
    vertex_t r;
    longint n, st, en, span, p, total, phase, z, x, y, nx, c, s, sx, sy;
    bit outer, last, neg;
    longint atan_tab [0:23];
    r = '0;
    for (int k = 0; k < 24; k++) atan_tab[k] = ATAN_TURNS[k];
    n = seg_r;
    if (n == 0) n = 1;
    if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
    r.sl = {1'b0, bs} + {7'b0, vi};
    if (vi > 2 * n + 3) begin
      r.err = 1'b1;
      return r;
    end
    if (vi == 0) begin
      p = 0; outer = 0; last = 0;
    end else if (vi == 2 * n + 3) begin
      p = n; outer = 1; last = 1;
    end else begin
      p = (vi - 1) >> 1; outer = ((vi - 1) & 1) != 0; last = 0;
    end
    st = sa_r >= 23040 ? sa_r - 23040 : sa_r;
    en = ea_r >= 23040 ? ea_r - 23040 : ea_r;
    span = st <= en ? en - st : 23040 - st + en;
    total = (st << 16) + ((p * span) << 16) / n;
    if (total >= (longint'(23040) << 16)) total -= longint'(23040) << 16;
    phase = (total << 16) / 23040;
    z = phase; x = 652032874; y = 0; neg = 0;
    if (z >= (longint'(1) << 31)) z -= longint'(1) << 32;
    if (z > (longint'(1) << 30)) begin
      z -= longint'(1) << 31; neg = 1;
    end else if (z < -(longint'(1) << 30)) begin
      z += longint'(1) << 31; neg = 1;
    end
    for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_tab[i];
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_tab[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    sx = longint'($signed(rx_r));
    sy = longint'($signed(ry_r));
    if (outer) begin
      sx += longint'($signed(th_r));
      sy += longint'($signed(th_r));
    end
    r.vx = 16'(sat16(longint'($signed(cx_r))
                     + floor_shr(c * sx + (longint'(1) << 29), 30)));
    r.vy = 16'(sat16(longint'($signed(cy_r))
                     + floor_shr(s * sy + (longint'(1) << 29), 30)));
    r.outer = outer;
    r.last = last;
    return r;
  endfunction

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result slot=%0d", slot);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (vertex_x !== e.vx) begin
          $error("vertex_x exp %0d got %0d", e.vx, vertex_x); errors++;
        end
        if (vertex_y !== e.vy) begin
          $error("vertex_y exp %0d got %0d", e.vy, vertex_y); errors++;
        end
        if (slot !== e.sl) begin
          $error("slot exp %0d got %0d", e.sl, slot); errors++;
        end
        if (outer_ring !== e.outer) begin
          $error("outer_ring exp %0d got %0d", e.outer, outer_ring); errors++;
        end
        if (last_vertex !== e.last) begin
          $error("last_vertex exp %0d got %0d", e.last, last_vertex); errors++;
        end
        if (index_error !== e.err) begin
          $error("index_error exp %0d got %0d", e.err, index_error); errors++;
        end
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_CENTER_X:    cx_r = val;
      REG_CENTER_Y:    cy_r = val;
      REG_RADIUS_X:    rx_r = val;
      REG_RADIUS_Y:    ry_r = val;
      REG_START_ANGLE: sa_r = val[14:0];
      REG_END_ANGLE:   ea_r = val[14:0];
      REG_THICKNESS:   th_r = val;
      REG_SEGMENTS:    seg_r = val[8:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_arc(logic [15:0] cx, logic [15:0] cy, logic [15:0] rx,
                         logic [15:0] ry, logic [14:0] sa, logic [14:0] ea,
                         logic [15:0] th, logic [8:0] sg);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS_X, rx);
    write_reg(REG_RADIUS_Y, ry);
    write_reg(REG_START_ANGLE, {1'b0, sa});
    write_reg(REG_END_ANGLE, {1'b0, ea});
    write_reg(REG_THICKNESS, th);
    write_reg(REG_SEGMENTS, {7'd0, sg});
    cfg_write <= 1'b0;
  endtask

  // item is predicted when it is taken; start stays high across back-to-back items
  task automatic send_item(logic [9:0] vi, logic [15:0] bs);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    vertex_index <= vi;
    base_slot <= bs;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q = {expected_q, predict_vertex(vi, bs)};
  endtask

  task automatic end_items();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    logic [9:0] last_idx;
    set_arc(16'h0000, 16'h0000, 16'h1000, 16'h1000, 15'd0, 15'd5760, 16'h0400, 9'd4);
    for (int i = 0; i < 13; i++) send_item(i[9:0], 16'hFFFF);
    send_item(10'd1023, 16'hFFFF);
    end_items();
    set_arc(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 15'd23039, 15'd100, 16'h7FFF, 9'd256);
    last_idx = 10'd515;
    send_item(10'd0, 16'd0);
    send_item(10'd1, 16'd0);
    send_item(10'd2, 16'd0);
    send_item(last_idx, 16'd0);
    send_item(10'd516, 16'd0);
    end_items();
    // zero and oversize segment counts, equal angles, angles past a full turn
    set_arc(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 15'd30000, 15'd30000, 16'h8000, 9'd0);
    send_item(10'd0, 16'h1234); send_item(10'd3, 16'h1234); send_item(10'd5, 16'h1234);
    send_item(10'd6, 16'h1234);
    end_items();
    set_arc(16'h0100, 16'hFF00, 16'h2000, 16'h3000, 15'd32767, 15'd0, 16'h0000, 9'd511);
    send_item(10'd0, 16'd7); send_item(10'd300, 16'd7); send_item(10'd515, 16'd7);
    send_item(10'd516, 16'd7);
    end_items();
  endtask

  task automatic test_random(int n_items, int pct);
    int n;
    idle_pct = pct;
    set_arc(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            15'($urandom_range(23039)), 15'($urandom_range(32767)), 16'($urandom),
            9'($urandom_range(3) == 0 ? $urandom_range(511) : $urandom_range(1, 16)));
    n = seg_r == 0 ? 1 : (seg_r > 256 ? 256 : seg_r);
    for (int i = 0; i < n_items; i++)
      send_item(10'($urandom_range(9) == 0 ? $urandom_range(1023) :
                    $urandom_range(2 * n + 3)), 16'($urandom));
    end_items();
  endtask

  initial begin
    cx_r = 0; cy_r = 0; rx_r = 4096; ry_r = 4096; th_r = 0;
    sa_r = 0; ea_r = 0; seg_r = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (int ph = 0; ph < 24; ph++)
      test_random(32, ph % 4 == 0 ? 0 : (ph % 4 == 2 ? 20 : 63));
    drain();
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/asvg_pkg.sv
rtl/core/arc_strip_vertex_generator.sv
rtl/core/asvg_checker.sv
sim/tb_arc_strip_vertex_generator.sv
